// ===== rtl/aslnu_pkg.sv =====
package aslnu_pkg;

   localparam int CMD_W  = 8;
   localparam int OUT_W  = 16;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 8;

   typedef logic signed [CMD_W-1:0] cmd_type;
   typedef logic signed [OUT_W-1:0] drive_type;

   // register indexes of the configuration port
   localparam logic [CSR_IW-1:0] CSR_SLEW_ENABLE    = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_FWD_SLEW_RATE  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_TURN_SLEW_RATE = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_KEEP_RATIO     = 2'd3;

endpackage

// ===== rtl/aslnu_req_if.sv =====
interface aslnu_req_if;
   import aslnu_pkg::*;

   logic    valid;
   logic    ready;
   cmd_type fwd_cmd;
   cmd_type turn_cmd;

   modport source (output valid, output fwd_cmd, output turn_cmd, input ready);
   modport sink   (input valid, input fwd_cmd, input turn_cmd, output ready);

endinterface

// ===== rtl/aslnu_rsp_if.sv =====
interface aslnu_rsp_if;
   import aslnu_pkg::*;

   logic      valid;
   logic      ready;
   drive_type fwd_out;
   drive_type turn_out;

   modport source (output valid, output fwd_out, output turn_out, input ready);
   modport sink   (input valid, input fwd_out, input turn_out, output ready);

endinterface

// ===== rtl/arcade_slew_limit_normalize_unit.sv =====
// Channel  Port     Dir   Beat contents
// -------  -------  ----  ----------------------------------------
// request  req_ch   in    fwd_cmd, turn_cmd (signed 8 bits each)
// result   rsp_ch   out   fwd_out, turn_out (signed Q2.14, 16 bits)
// config   csr_*    in    csr_we, csr_index, csr_wdata; no read-back
//
// From acceptance to rsp_ch.valid a beat passes the limit state, then the
// one-bit-per-cycle divider, which serves both axes in turn.
// One beat is in flight at a time; req_ch.ready is high only when idle.
// The result is held in registers until the sink takes it.
// Synchronous reset restores the register defaults and clears the last slew-limited commands.
module arcade_slew_limit_normalize_unit #(
   parameter int FULL_SCALE = 127,
   parameter int FRAC_BITS  = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   aslnu_req_if.sink                       req_ch,
   aslnu_rsp_if.source                     rsp_ch,
   input  logic                            csr_we,
   input  logic [aslnu_pkg::CSR_IW-1:0]    csr_index,
   input  logic [aslnu_pkg::CSR_DW-1:0]    csr_wdata
);
   import aslnu_pkg::*;

   localparam int NW  = CMD_W + FRAC_BITS;
   localparam int FSW = $clog2(FULL_SCALE + 1);
   localparam int DW  = (FSW > CMD_W + 1) ? FSW : CMD_W + 1;
   localparam logic [DW-1:0] FS_DEN = DW'(FULL_SCALE);
   localparam logic [NW-1:0] POS_MAX = NW'(32767);
   localparam logic [NW-1:0] NEG_MAX = NW'(32768);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LIMIT = 3'd1;
   localparam logic [2:0] ST_FGO   = 3'd2;
   localparam logic [2:0] ST_FWAIT = 3'd3;
   localparam logic [2:0] ST_TGO   = 3'd4;
   localparam logic [2:0] ST_TWAIT = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic             slew_en_ff;
   logic [7:0]       fwd_rate_ff, turn_rate_ff;
   logic             keep_ratio_ff;
   cmd_type          prev_fwd_ff, prev_turn_ff;
   cmd_type          fwd_cmd_ff, turn_cmd_ff;
   cmd_type          fwd_ff, fwd_in;
   cmd_type          turn_ff, turn_in;
   logic [DW-1:0]    den_ff, den_in;
   drive_type        fwd_out_ff, turn_out_ff;
   logic [CMD_W-1:0] fwd_mag, turn_mag, cur_mag;
   logic [CMD_W:0]   mag_sum;
   logic             cur_neg;
   drive_type        cur_drive;
   logic             div_start, div_done;
   logic [NW-1:0]    div_num, div_quo;

   function automatic cmd_type limit_axis(cmd_type want, cmd_type last, logic [7:0] rate);
      logic signed [9:0] d;
      logic signed [9:0] r;
      logic signed [9:0] res;
      d = 10'(want) - 10'(last);
      r = signed'({2'b00, rate});
      if (d > r) res = 10'(last) + r;
      else if (d < -r) res = 10'(last) - r;
      else res = 10'(want);
      return res[CMD_W-1:0];
   endfunction

   // -128 gives 128 here, held correctly as an unsigned magnitude
   function automatic logic [CMD_W-1:0] mag_of(cmd_type v);
      return v[CMD_W-1] ? CMD_W'(-v) : v;
   endfunction

   always_comb begin
      if (slew_en_ff) begin
         fwd_in  = limit_axis(fwd_cmd_ff, prev_fwd_ff, fwd_rate_ff);
         turn_in = limit_axis(turn_cmd_ff, prev_turn_ff, turn_rate_ff);
      end else begin
         fwd_in  = fwd_cmd_ff;
         turn_in = turn_cmd_ff;
      end
      fwd_mag = mag_of(fwd_in);
      turn_mag = mag_of(turn_in);
      mag_sum = {1'b0, fwd_mag} + {1'b0, turn_mag};
      if (keep_ratio_ff && (DW'(mag_sum) > FS_DEN)) den_in = DW'(mag_sum);
      else den_in = FS_DEN;
   end

   // divider operand and result sign follow the axis in progress
   assign cur_neg   = (state_ff == ST_FGO || state_ff == ST_FWAIT) ? fwd_ff[CMD_W-1]
                                                                   : turn_ff[CMD_W-1];
   assign cur_mag   = (state_ff == ST_FGO) ? mag_of(fwd_ff) : mag_of(turn_ff);
   assign div_num   = {cur_mag, {FRAC_BITS{1'b0}}};
   assign div_start = (state_ff == ST_FGO) || (state_ff == ST_TGO);

   always_comb begin
      if (!cur_neg) cur_drive = (div_quo > POS_MAX) ? 16'sd32767 : div_quo[OUT_W-1:0];
      else if (div_quo > NEG_MAX) cur_drive = -16'sd32768;
      else cur_drive = OUT_W'(-div_quo);
   end

   aslnu_div #(
      .NW (NW),
      .DW (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_ch.valid) state_in = ST_LIMIT;
         ST_LIMIT: state_in = ST_FGO;
         ST_FGO:   state_in = ST_FWAIT;
         ST_FWAIT: if (div_done) state_in = ST_TGO;
         ST_TGO:   state_in = ST_TWAIT;
         ST_TWAIT: if (div_done) state_in = ST_OUT;
         ST_OUT:   if (rsp_ch.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slew_en_ff    <= 1'b1;
         fwd_rate_ff   <= 8'd7;
         turn_rate_ff  <= 8'd7;
         keep_ratio_ff <= 1'b0;
         prev_fwd_ff   <= '0;
         prev_turn_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SLEW_ENABLE:    slew_en_ff    <= csr_wdata[0];
               CSR_FWD_SLEW_RATE:  fwd_rate_ff   <= csr_wdata;
               CSR_TURN_SLEW_RATE: turn_rate_ff  <= csr_wdata;
               CSR_KEEP_RATIO:     keep_ratio_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (state_ff == ST_LIMIT && slew_en_ff) begin
            prev_fwd_ff  <= fwd_in;
            prev_turn_ff <= turn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_ch.valid) begin
         fwd_cmd_ff  <= req_ch.fwd_cmd;
         turn_cmd_ff <= req_ch.turn_cmd;
      end
      if (state_ff == ST_LIMIT) begin
         fwd_ff  <= fwd_in;
         turn_ff <= turn_in;
         den_ff  <= den_in;
      end
      if (state_ff == ST_FWAIT && div_done) fwd_out_ff <= cur_drive;
      if (state_ff == ST_TWAIT && div_done) turn_out_ff <= cur_drive;
   end

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = (state_ff == ST_OUT);
   assign rsp_ch.fwd_out  = fwd_out_ff;
   assign rsp_ch.turn_out = turn_out_ff;

endmodule

// ===== rtl/aslnu_div.sv =====
// Restoring divider, one quotient bit per cycle.
module aslnu_div #(
   parameter int NW = 22,
   parameter int DW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   assign trial = {rem_ff, quo_ff[NW-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so DW bits hold it
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== verif/arcade_slew_limit_normalize_unit_tb.sv =====
`timescale 1ns / 100ps

module arcade_slew_limit_normalize_unit_tb;
   import aslnu_pkg::*;

   localparam int NORM_FULL_SCALE = 127;
   localparam int NORM_FRAC_BITS  = 14;
   localparam int STALL_LIMIT     = 3000;
   localparam int LONG_HOLD       = 400;
   localparam int N_PHASES        = 10;
   localparam int PHASE_BEATS     = 100;
   localparam int N_ROWS          = 30;

   typedef struct {
      drive_type fwd;
      drive_type turn;
   } drive_pair_type;

   typedef enum {ROW_CMD, ROW_SLEW_EN, ROW_FWD_RATE, ROW_TURN_RATE, ROW_KEEP} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           a;      // fwd command, or register value
      int           b;      // turn command
      bit           typed;
      int           exp_fwd;
      int           exp_turn;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CSR_IW-1:0]   csr_index;
   logic [CSR_DW-1:0]   csr_wdata;

   aslnu_req_if req_ch ();
   aslnu_rsp_if rsp_ch ();

   arcade_slew_limit_normalize_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and stored outputs
   logic        cfg_slew_on;
   logic [7:0]  cfg_fwd_rate;
   logic [7:0]  cfg_turn_rate;
   logic        cfg_keep_ratio;
   cmd_type     last_fwd;
   cmd_type     last_turn;

   drive_pair_type expected_drive_q[$];
   int             mismatches;
   int             stall_count;
   bit             idling_on;
   bit             hold_off_req;
   stim_row_type   directed_rows[N_ROWS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic cmd_type slew_axis(cmd_type want, cmd_type last, logic [7:0] rate);
      int step;
      step = int'(want) - int'(last);
      if (step > int'(rate))
         return cmd_type'(int'(last) + int'(rate));
      if (step < -int'(rate))
         return cmd_type'(int'(last) - int'(rate));
      return want;
   endfunction

   function automatic drive_type scale_axis(cmd_type v, longint divisor);
      longint q;
      q = (longint'(v) * (longint'(1) << NORM_FRAC_BITS)) / divisor;
      if (q > 32767)
         q = 32767;
      if (q < -32768)
         q = -32768;
      return drive_type'(q);
   endfunction

   // slew limit, then normalise; keeps the stored outputs up to date
   function automatic drive_pair_type condition_commands(cmd_type f_in, cmd_type t_in);
      cmd_type        f;
      cmd_type        t;
      int             mag_sum;
      longint         divisor;
      drive_pair_type res;
      f = f_in;
      t = t_in;
      if (cfg_slew_on) begin
         f = slew_axis(f, last_fwd, cfg_fwd_rate);
         t = slew_axis(t, last_turn, cfg_turn_rate);
         last_fwd  = f;
         last_turn = t;
      end
      mag_sum = (f < 0 ? -int'(f) : int'(f)) + (t < 0 ? -int'(t) : int'(t));
      divisor = NORM_FULL_SCALE;
      if (cfg_keep_ratio && mag_sum > NORM_FULL_SCALE)
         divisor = mag_sum;
      res.fwd  = scale_axis(f, divisor);
      res.turn = scale_axis(t, divisor);
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic send_cmd(cmd_type f, cmd_type t, bit typed, int ef, int et);
      drive_pair_type predicted;
      int gap;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.fwd_cmd  <= f;
      req_ch.turn_cmd <= t;
      do @(posedge clock); while (!req_ch.ready);
      predicted = condition_commands(f, t);
      if (typed) begin
         predicted.fwd  = drive_type'(ef);
         predicted.turn = drive_type'(et);
      end
      expected_drive_q.push_back(predicted);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_drive_q.size() != 0) @(negedge clock);
   endtask

   // block must be idle here
   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SLEW_ENABLE:    cfg_slew_on    = val[0];
         CSR_FWD_SLEW_RATE:  cfg_fwd_rate   = val;
         CSR_TURN_SLEW_RATE: cfg_turn_rate  = val;
         CSR_KEEP_RATIO:     cfg_keep_ratio = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_rate();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom_range(1, 16));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic cmd_type pick_cmd();
      case ($urandom_range(0, 11))
         0:       return cmd_type'(-128);
         1:       return cmd_type'(127);
         2:       return cmd_type'(-127);
         3:       return cmd_type'(0);
         default: return cmd_type'($urandom_range(0, 255));
      endcase
   endfunction

   // sink side: random back-pressure, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left = $urandom_range(1, 17) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // result checker and stall watchdog
   always @(posedge clock) begin
      drive_pair_type want;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_count <= 0;
         else
            stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("[arcade_slew_limit_normalize_unit] ERROR");
            $finish;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_drive_q.size() == 0) begin
               report_mismatch("beat with nothing expected, fwd_out",
                               int'(rsp_ch.fwd_out), 0);
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_ch.fwd_out !== want.fwd)
                  report_mismatch("fwd_out", int'(rsp_ch.fwd_out), int'(want.fwd));
               if (rsp_ch.turn_out !== want.turn)
                  report_mismatch("turn_out", int'(rsp_ch.turn_out), int'(want.turn));
            end
         end
      end
   end

   initial begin
      int beats;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.fwd_cmd  = '0;
      req_ch.turn_cmd = '0;
      rsp_ch.ready    = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      mismatches      = 0;
      stall_count     = 0;
      idling_on       = 1'b1;
      hold_off_req    = 1'b0;
      cfg_slew_on     = 1'b1;
      cfg_fwd_rate    = 8'd7;
      cfg_turn_rate   = 8'd7;
      cfg_keep_ratio  = 1'b0;
      last_fwd        = '0;
      last_turn       = '0;

      directed_rows = '{
         '{ROW_CMD,       0,    0,    1'b1, 0,      0},
         '{ROW_CMD,       127,  -127, 1'b1, 903,    -903},
         '{ROW_CMD,       127,  -127, 1'b0, 0,      0},
         '{ROW_SLEW_EN,   0,    0,    1'b0, 0,      0},
         '{ROW_CMD,       127,  127,  1'b1, 16384,  16384},
         '{ROW_CMD,       -127, -127, 1'b1, -16384, -16384},
         '{ROW_CMD,       -128, -128, 1'b1, -16513, -16513},
         '{ROW_CMD,       0,    127,  1'b1, 0,      16384},
         '{ROW_KEEP,      1,    0,    1'b0, 0,      0},
         '{ROW_CMD,       127,  127,  1'b1, 8192,   8192},
         '{ROW_CMD,       -128, 127,  1'b0, 0,      0},
         '{ROW_CMD,       100,  27,   1'b0, 0,      0},
         '{ROW_CMD,       100,  28,   1'b0, 0,      0},
         '{ROW_CMD,       -128, 0,    1'b1, -16384, 0},
         '{ROW_SLEW_EN,   1,    0,    1'b0, 0,      0},
         '{ROW_FWD_RATE,  255,  0,    1'b0, 0,      0},
         '{ROW_TURN_RATE, 255,  0,    1'b0, 0,      0},
         '{ROW_CMD,       -128, 127,  1'b0, 0,      0},
         '{ROW_CMD,       127,  -128, 1'b0, 0,      0},
         '{ROW_FWD_RATE,  0,    0,    1'b0, 0,      0},
         '{ROW_TURN_RATE, 0,    0,    1'b0, 0,      0},
         '{ROW_CMD,       50,   -50,  1'b0, 0,      0},
         '{ROW_FWD_RATE,  10,   0,    1'b0, 0,      0},
         '{ROW_TURN_RATE, 3,    0,    1'b0, 0,      0},
         '{ROW_CMD,       20,   -20,  1'b0, 0,      0},
         // step exactly at the rate on both axes
         '{ROW_CMD,       107,  -122, 1'b0, 0,      0},
         '{ROW_CMD,       -128, 127,  1'b0, 0,      0},
         '{ROW_KEEP,      0,    0,    1'b0, 0,      0},
         '{ROW_CMD,       1,    -1,   1'b0, 0,      0},
         '{ROW_CMD,       -1,   1,    1'b0, 0,      0}
      };

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CMD: begin
               send_cmd(cmd_type'(directed_rows[i].a), cmd_type'(directed_rows[i].b),
                        directed_rows[i].typed, directed_rows[i].exp_fwd,
                        directed_rows[i].exp_turn);
            end
            ROW_SLEW_EN: begin
               drain_results();
               write_reg(CSR_SLEW_ENABLE, 8'(directed_rows[i].a));
            end
            ROW_FWD_RATE: begin
               drain_results();
               write_reg(CSR_FWD_SLEW_RATE, 8'(directed_rows[i].a));
            end
            ROW_TURN_RATE: begin
               drain_results();
               write_reg(CSR_TURN_SLEW_RATE, 8'(directed_rows[i].a));
            end
            default: begin
               drain_results();
               write_reg(CSR_KEEP_RATIO, 8'(directed_rows[i].a));
            end
         endcase
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain_results();
         case (ph)
            0: begin
               write_reg(CSR_SLEW_ENABLE, 8'd1);
               write_reg(CSR_FWD_SLEW_RATE, 8'd255);
               write_reg(CSR_TURN_SLEW_RATE, 8'd0);
               write_reg(CSR_KEEP_RATIO, 8'd1);
            end
            1: begin
               write_reg(CSR_SLEW_ENABLE, 8'd0);
               write_reg(CSR_KEEP_RATIO, 8'd1);
            end
            default: begin
               write_reg(CSR_SLEW_ENABLE, 8'($urandom_range(0, 3) != 0));
               write_reg(CSR_FWD_SLEW_RATE, pick_rate());
               write_reg(CSR_TURN_SLEW_RATE, pick_rate());
               write_reg(CSR_KEEP_RATIO, 8'($urandom_range(0, 1)));
            end
         endcase
         // last phase runs flat out; others mostly with gaps
         idling_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
         beats = PHASE_BEATS;
         for (int n = 0; n < beats; n++) begin
            if (ph == 1 && n == 20)
               hold_off_req = 1'b1;
            if (ph == 2 && n == 30)
               drain_results();
            send_cmd(pick_cmd(), pick_cmd(), 1'b0, 0, 0);
         end
      end

      drain_results();
      repeat (60) @(negedge clock);
      if (mismatches == 0 && expected_drive_q.size() == 0) begin
         $display("[arcade_slew_limit_normalize_unit] OK");
      end else begin
         $display("[arcade_slew_limit_normalize_unit] ERROR");
      end
      $finish;
   end

endmodule
